// File: design/lssd_pkg.sv
// shared types, timing constants and sync width table for the sweep/sync decoder
// no dependencies
package lssd_pkg;

    localparam int unsigned CLOCKS_PER_US = 48;

    localparam int unsigned SWEEP_MAX_CLK  = 15 * CLOCKS_PER_US;
    localparam int unsigned COUNT_MAX_CLK  = 8000 * CLOCKS_PER_US;
    localparam int unsigned PERIOD_MAX_CLK = 800 * CLOCKS_PER_US;
    localparam int unsigned SYNC_WIN_CLK   = 4 * CLOCKS_PER_US;

    localparam int unsigned SYNC_COUNT = 8;
    localparam int unsigned COUNT_W    = 19;

    // sync pulse centers in whole clocks, floored from tenths of a microsecond
    localparam int unsigned SYNC_MID [SYNC_COUNT] = '{
        (625 * CLOCKS_PER_US) / 10,
        (833 * CLOCKS_PER_US) / 10,
        (729 * CLOCKS_PER_US) / 10,
        (938 * CLOCKS_PER_US) / 10,
        (1040 * CLOCKS_PER_US) / 10,
        (1250 * CLOCKS_PER_US) / 10,
        (1150 * CLOCKS_PER_US) / 10,
        (1350 * CLOCKS_PER_US) / 10
    };

    typedef enum logic [1:0] {
        KIND_SWEEP_OK  = 2'd0,
        KIND_SWEEP_BAD = 2'd1,
        KIND_SYNC      = 2'd2,
        KIND_WIDE      = 2'd3
    } t_kind;

    localparam logic [1:0] STATION_0    = 2'd0;
    localparam logic [1:0] STATION_1    = 2'd1;
    localparam logic [1:0] STATION_NONE = 2'd2;

    typedef struct packed {
        logic        edge_rising;
        logic [31:0] edge_time;
    } t_in;

    typedef struct packed {
        t_kind              kind;
        logic [1:0]         sweep_slot;
        logic [COUNT_W-1:0] sweep_count;
        logic [2:0]         sync_code;
        logic [1:0]         station_now;
        logic               ootx_valid;
        logic               ootx_bit;
    } t_out;

    typedef struct packed {
        logic       hit;
        logic [2:0] code;
    } t_match;

endpackage

// File: design/lssd_sync_match.sv
// sync width matcher: first of the eight windows that holds the pulse width
// depends on lssd_pkg
module lssd_sync_match (
    input  logic [31:0]     i_width,
    output lssd_pkg::t_match o_match
);

    logic [lssd_pkg::SYNC_COUNT-1:0] w_in_win;

    always_comb begin
        for (int i = 0; i < lssd_pkg::SYNC_COUNT; i++) begin
            w_in_win[i] =
                (i_width >= 32'(lssd_pkg::SYNC_MID[i] - lssd_pkg::SYNC_WIN_CLK)) &&
                (i_width <= 32'(lssd_pkg::SYNC_MID[i] + lssd_pkg::SYNC_WIN_CLK));
        end
    end

    // priority: lowest index wins
    always_comb begin
        o_match = '0;
        for (int i = lssd_pkg::SYNC_COUNT - 1; i >= 0; i--) begin
            if (w_in_win[i]) begin
                o_match.hit  = 1'b1;
                o_match.code = 3'(i);
            end
        end
    end

endmodule

// File: design/lssd_core.sv
// decoder state and per-edge result logic, one edge per enabled cycle
// depends on lssd_pkg and lssd_sync_match
module lssd_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_fire,
    input  lssd_pkg::t_in  i_item,
    output logic           o_has_result,
    output lssd_pkg::t_out o_result
);

    logic [31:0] r_fall, n_fall;
    logic [31:0] r_rise, n_rise;
    logic [31:0] r_zero, n_zero;
    logic        r_axis, n_axis;
    logic [1:0]  r_station, n_station;
    logic        r_sweep_seen, n_sweep_seen;
    logic        r_skip_seen, n_skip_seen;
    logic        r_noskip_seen, n_noskip_seen;

    logic [31:0] w_width;
    logic [31:0] w_period;
    logic [31:0] w_mid;
    logic [31:0] w_delta;
    logic        w_sweep_ok;
    lssd_pkg::t_match w_match;

    assign w_width  = i_item.edge_time - r_fall;
    assign w_period = i_item.edge_time - r_rise;
    assign w_mid    = i_item.edge_time - {1'b0, w_width[31:1]};
    assign w_delta  = w_mid - r_zero;
    assign w_sweep_ok = !r_sweep_seen && (r_station != lssd_pkg::STATION_NONE) &&
                        (w_delta < 32'(lssd_pkg::COUNT_MAX_CLK));

    lssd_sync_match u_match (
        .i_width (w_width),
        .o_match (w_match)
    );

    always_comb begin
        n_fall        = r_fall;
        n_rise        = r_rise;
        n_zero        = r_zero;
        n_axis        = r_axis;
        n_station     = r_station;
        n_sweep_seen  = r_sweep_seen;
        n_skip_seen   = r_skip_seen;
        n_noskip_seen = r_noskip_seen;
        o_has_result  = 1'b0;
        o_result      = '0;

        if (!i_item.edge_rising) begin
            n_fall = i_item.edge_time;
        end else begin
            n_rise       = i_item.edge_time;
            o_has_result = 1'b1;
            if (w_width < 32'(lssd_pkg::SWEEP_MAX_CLK)) begin
                // laser sweep
                n_sweep_seen  = 1'b1;
                n_skip_seen   = 1'b0;
                n_noskip_seen = 1'b0;
                n_station     = lssd_pkg::STATION_NONE;
                if (w_sweep_ok) begin
                    o_result.kind        = lssd_pkg::KIND_SWEEP_OK;
                    o_result.sweep_slot  = {r_station[0], r_axis};
                    o_result.sweep_count = w_delta[lssd_pkg::COUNT_W-1:0];
                end else begin
                    o_result.kind = lssd_pkg::KIND_SWEEP_BAD;
                end
            end else begin
                // wide pulse: restart sync tracking after a sweep or a long gap
                if (r_sweep_seen || (w_period > 32'(lssd_pkg::PERIOD_MAX_CLK))) begin
                    n_station     = lssd_pkg::STATION_NONE;
                    n_sweep_seen  = 1'b0;
                    n_skip_seen   = 1'b0;
                    n_noskip_seen = 1'b0;
                end
                if (!w_match.hit) begin
                    o_result.kind = lssd_pkg::KIND_WIDE;
                end else begin
                    o_result.kind      = lssd_pkg::KIND_SYNC;
                    o_result.sync_code = w_match.code;
                    if (!w_match.code[2]) begin
                        n_zero        = r_fall;
                        n_axis        = w_match.code[1];
                        if (n_skip_seen) begin
                            n_station           = lssd_pkg::STATION_0;
                            o_result.ootx_valid = 1'b1;
                            o_result.ootx_bit   = w_match.code[0];
                        end
                        n_noskip_seen = 1'b1;
                    end else begin
                        n_skip_seen = 1'b1;
                        if (n_noskip_seen) begin
                            n_station = lssd_pkg::STATION_1;
                        end
                    end
                end
            end
            o_result.station_now = n_station;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fall        <= '0;
            r_rise        <= '0;
            r_zero        <= '0;
            r_axis        <= 1'b0;
            r_station     <= lssd_pkg::STATION_NONE;
            r_sweep_seen  <= 1'b0;
            r_skip_seen   <= 1'b0;
            r_noskip_seen <= 1'b0;
        end else if (i_fire) begin
            r_fall        <= n_fall;
            r_rise        <= n_rise;
            r_zero        <= n_zero;
            r_axis        <= n_axis;
            r_station     <= n_station;
            r_sweep_seen  <= n_sweep_seen;
            r_skip_seen   <= n_skip_seen;
            r_noskip_seen <= n_noskip_seen;
        end
    end

endmodule

// File: design/laser_sweep_sync_pulse_decoder.sv
// top level of the sweep/sync pulse decoder: input register, core, result register
// depends on lssd_pkg and lssd_core
//
//  channel | direction | payload          | handshake
//  --------+-----------+------------------+----------------------------
//  in      | input     | lssd_pkg::t_in   | i_in_valid / o_in_stall
//  out     | output    | lssd_pkg::t_out  | o_out_valid / i_out_stall
//
// one edge transaction is taken every clock while the output drains
// a rising edge gives its result from the result register: the input register
// feeds the core's subtracts and window compares straight into the result register
// a falling edge gives no result and only updates the stored fall time
// reset is synchronous, active low, and puts the station back to unknown
// while the result register is held, one more transaction waits in the input register
module laser_sweep_sync_pulse_decoder (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  lssd_pkg::t_in  i_in_data,
    output logic           o_in_stall,
    output logic           o_out_valid,
    output lssd_pkg::t_out o_out_data,
    input  logic           i_out_stall
);

    logic           r_in_valid;
    lssd_pkg::t_in  r_in;
    logic           r_out_valid;
    lssd_pkg::t_out r_out;

    logic           w_advance;
    logic           w_fire;
    logic           w_has_result;
    lssd_pkg::t_out w_result;

    // the result register can take a new value unless it holds one being stalled
    assign w_advance  = !(r_out_valid && i_out_stall);
    // the held transaction is processed when it can move on
    assign w_fire     = r_in_valid && w_advance;
    // input register stays full only while its transaction cannot move on
    assign o_in_stall = r_in_valid && !w_advance;

    lssd_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (w_fire),
        .i_item       (r_in),
        .o_has_result (w_has_result),
        .o_result     (w_result)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall) begin
            r_in <= i_in_data;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= w_fire && w_has_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
